FILE: design/psci_pkg.sv
// ----------------------------------------------------------------------------
// psci_pkg
// Shared widths, register codes, luma weights and pipeline payload types
// for the pixel saturation / contrast invert unit.
// ----------------------------------------------------------------------------
package psci_pkg;

  // channel and arithmetic widths
  localparam int CH_W    = 8;
  localparam int SCALE_W = 16;
  localparam int LUMA_W  = 25;
  localparam int NUM_W   = 16;               // ceil numerator d*hi + delta - 1
  localparam int PROD_W  = SCALE_W + CH_W;   // d*scale and scale*delta
  localparam int IDX_W   = 2;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_MODE  = 2'd0;
  localparam logic [IDX_W-1:0] REG_SAT   = 2'd1;
  localparam logic [IDX_W-1:0] REG_DARK  = 2'd2;
  localparam logic [IDX_W-1:0] REG_LIGHT = 2'd3;

  // register reset values
  localparam logic [SCALE_W-1:0] SAT_RST   = 16'd4096;
  localparam logic [SCALE_W-1:0] DARK_RST  = 16'd1434;
  localparam logic [SCALE_W-1:0] LIGHT_RST = 16'd2662;

  // mode codes
  localparam logic MODE_SAT      = 1'b0;
  localparam logic MODE_CONTRAST = 1'b1;

  // Rec.709 luma weights, Q0.16, and the half-scale threshold
  localparam logic [LUMA_W-1:0] LUMA_WR   = 25'd13933;
  localparam logic [LUMA_W-1:0] LUMA_WG   = 25'd46871;
  localparam logic [LUMA_W-1:0] LUMA_WB   = 25'd4732;
  localparam logic [LUMA_W-1:0] LUMA_HALF = 25'd8355840;

  localparam logic [CH_W-1:0] CH_MAX = 8'd255;

  // three color channels, index 0 red, 1 green, 2 blue
  typedef logic [2:0][CH_W-1:0] rgb_t;

  // configuration registers as seen by the datapath
  typedef struct packed {
    logic               mode;
    logic [SCALE_W-1:0] sat;
    logic [SCALE_W-1:0] dark;
    logic [SCALE_W-1:0] light;
  } cfg_t;

  // per-pixel info carried down the whole pipe
  typedef struct packed {
    rgb_t            ch;     // channels entering the saturation step
    logic [CH_W-1:0] alpha;
    logic            mode;
    logic            dark;
  } tag_t;

  // after range and scale selection
  typedef struct packed {
    tag_t               tag;
    logic [CH_W-1:0]    hi;
    logic [CH_W-1:0]    delta;
    rgb_t               d;      // hi - ch per channel
    logic [SCALE_W-1:0] scale;
  } front_t;

  // after the multipliers
  typedef struct packed {
    tag_t                   tag;
    logic [CH_W-1:0]        hi;
    logic [CH_W-1:0]        delta;
    logic [2:0][PROD_W-1:0] dscale;
    logic [2:0][NUM_W-1:0]  dhi;
    logic [PROD_W-1:0]      sdelta;
  } prod_t;

  // side info riding along the divider
  typedef struct packed {
    tag_t            tag;
    logic [CH_W-1:0] hi;
    logic            gray;
    logic            capped;
    rgb_t            drop_nc;   // drop when the scale is not capped
  } side_t;

endpackage

FILE: design/psci_front.sv
// ----------------------------------------------------------------------------
// psci_front
// Input stages: optional inversion and luma products, then dark decision,
// channel max/min, per-channel distance and scale selection.
// ----------------------------------------------------------------------------
module psci_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  psci_pkg::rgb_t  pix_in,
  input  logic [7:0]      alpha_in,
  input  psci_pkg::cfg_t  cfg,
  output logic            out_valid,
  output psci_pkg::front_t out
);
  import psci_pkg::*;

  // stage A registers
  logic              a_valid;
  rgb_t              a_ch;
  logic [CH_W-1:0]   a_alpha;
  logic              a_mode;
  logic [LUMA_W-1:0] a_pr;
  logic [LUMA_W-1:0] a_pg;
  logic [LUMA_W-1:0] a_pb;

  // stage B next values
  logic [LUMA_W-1:0] luma;
  logic              dark;
  logic [CH_W-1:0]   hi;
  logic [CH_W-1:0]   lo;
  front_t            b_next;

  // stage A: invert in contrast mode, luma weights on the original pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
    for (int i = 0; i < 3; i++) begin
      a_ch[i] <= (cfg.mode == MODE_CONTRAST) ? ~pix_in[i] : pix_in[i];
    end
    a_alpha <= alpha_in;
    a_mode  <= cfg.mode;
    a_pr    <= LUMA_WR * LUMA_W'(pix_in[0]);
    a_pg    <= LUMA_WG * LUMA_W'(pix_in[1]);
    a_pb    <= LUMA_WB * LUMA_W'(pix_in[2]);
  end

  // stage B: dark flag, range, distances, scale pick
  always_comb begin
    luma = a_pr + a_pg + a_pb;
    dark = (luma < LUMA_HALF);
    hi = a_ch[0];
    lo = a_ch[0];
    for (int i = 1; i < 3; i++) begin
      if (a_ch[i] > hi) hi = a_ch[i];
      if (a_ch[i] < lo) lo = a_ch[i];
    end
    b_next.tag.ch    = a_ch;
    b_next.tag.alpha = a_alpha;
    b_next.tag.mode  = a_mode;
    b_next.tag.dark  = dark;
    b_next.hi        = hi;
    b_next.delta     = hi - lo;
    for (int i = 0; i < 3; i++) begin
      b_next.d[i] = hi - a_ch[i];
    end
    if (a_mode == MODE_CONTRAST) begin
      b_next.scale = dark ? cfg.dark : cfg.light;
    end else begin
      b_next.scale = cfg.sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= a_valid;
    end
    out <= b_next;
  end

endmodule

FILE: design/psci_mul.sv
// ----------------------------------------------------------------------------
// psci_mul
// Multiplier stage (distance times scale, distance times max, scale times
// range) and the following stage that decides capping, rounds the uncapped
// drop and forms the numerator for the capped division.
// ----------------------------------------------------------------------------
module psci_mul #(
  parameter int SCALE_FRAC_BITS = 12
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  psci_pkg::front_t           in,
  output logic                       out_valid,
  output logic [2:0][psci_pkg::NUM_W-1:0] num,
  output logic [psci_pkg::CH_W-1:0]  delta,
  output psci_pkg::side_t            side
);
  import psci_pkg::*;

  localparam int CMP_W = PROD_W + 1;
  localparam logic [CMP_W-1:0] RND = CMP_W'((1 << SCALE_FRAC_BITS) - 1);

  // stage C
  logic  c_valid;
  prod_t c;

  // stage D next values
  logic [CMP_W-1:0]      hi_sh;
  logic [2:0][CMP_W-1:0] dsum;
  logic [2:0][CMP_W-1:0] dshift;
  side_t                 d_side;
  logic [2:0][NUM_W-1:0] d_num;

  // stage C: products
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= in_valid;
    end
    c.tag   <= in.tag;
    c.hi    <= in.hi;
    c.delta <= in.delta;
    for (int i = 0; i < 3; i++) begin
      c.dscale[i] <= PROD_W'(in.d[i]) * PROD_W'(in.scale);
      c.dhi[i]    <= NUM_W'(in.d[i]) * NUM_W'(in.hi);
    end
    c.sdelta <= PROD_W'(in.scale) * PROD_W'(in.delta);
  end

  // stage D: cap test, rounded-up uncapped drop, ceil numerator
  always_comb begin
    hi_sh         = CMP_W'(c.hi) << SCALE_FRAC_BITS;
    d_side.tag    = c.tag;
    d_side.hi     = c.hi;
    d_side.gray   = (c.delta == '0);
    d_side.capped = (CMP_W'(c.sdelta) >= hi_sh);
    for (int i = 0; i < 3; i++) begin
      dsum[i]   = CMP_W'(c.dscale[i]) + RND;
      dshift[i] = dsum[i] >> SCALE_FRAC_BITS;
      d_side.drop_nc[i] = (dshift[i] > CMP_W'(c.hi)) ? c.hi : dshift[i][CH_W-1:0];
      d_num[i]  = c.dhi[i] + NUM_W'(c.delta) - NUM_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= c_valid;
    end
    side  <= d_side;
    num   <= d_num;
    delta <= c.delta;
  end

endmodule

FILE: design/psci_div.sv
// ----------------------------------------------------------------------------
// psci_div
// Pipelined restoring divider, one quotient bit per stage, three lanes.
// Gives floor(num / delta); the quotient never exceeds the channel max.
// ----------------------------------------------------------------------------
module psci_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic [2:0][psci_pkg::NUM_W-1:0]  num,
  input  logic [psci_pkg::CH_W-1:0]        delta,
  input  psci_pkg::side_t                  side_in,
  output logic                             out_valid,
  output psci_pkg::rgb_t                   quo_out,
  output psci_pkg::side_t                  side_out
);
  import psci_pkg::*;

  localparam int STAGES = CH_W;

  // stage registers
  logic                  vld [STAGES];
  logic [2:0][NUM_W-1:0] rem [STAGES];
  rgb_t                  quo [STAGES];
  logic [CH_W-1:0]       dvs [STAGES];
  side_t                 sd  [STAGES];

  // stage inputs
  logic                  vld_in [STAGES];
  logic [2:0][NUM_W-1:0] rem_in [STAGES];
  rgb_t                  quo_in [STAGES];
  logic [CH_W-1:0]       dvs_in [STAGES];
  side_t                 sd_in  [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    localparam int B = STAGES - 1 - k;

    logic [NUM_W-1:0]      trial;
    logic [2:0][NUM_W-1:0] rem_next;
    rgb_t                  quo_next;

    // chain to the previous stage
    if (k == 0) begin : g_first
      assign vld_in[k] = in_valid;
      assign rem_in[k] = num;
      assign quo_in[k] = '0;
      assign dvs_in[k] = delta;
      assign sd_in[k]  = side_in;
    end else begin : g_next
      assign vld_in[k] = vld[k-1];
      assign rem_in[k] = rem[k-1];
      assign quo_in[k] = quo[k-1];
      assign dvs_in[k] = dvs[k-1];
      assign sd_in[k]  = sd[k-1];
    end

    // compare and subtract for this quotient bit
    assign trial = NUM_W'(dvs_in[k]) << B;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rem_next[i] = rem_in[k][i];
        quo_next[i] = quo_in[k][i];
        if (rem_in[k][i] >= trial) begin
          rem_next[i]    = rem_in[k][i] - trial;
          quo_next[i][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld_in[k];
      end
      rem[k] <= rem_next;
      quo[k] <= quo_next;
      dvs[k] <= dvs_in[k];
      sd[k]  <= sd_in[k];
    end
  end

  assign out_valid = vld[STAGES-1];
  assign quo_out   = quo[STAGES-1];
  assign side_out  = sd[STAGES-1];

endmodule

FILE: design/pixel_saturation_contrast_invert_unit.sv
// ----------------------------------------------------------------------------
// pixel_saturation_contrast_invert_unit: HSV saturation scale / contrast bg
// Pipe: front stages A and B, multiplier stages C and D, the 8-stage divider, output register.
// Throughput: one pixel per clock, busy is always low; results are not stallable.
// Reset: synchronous rst clears the pipe and loads register reset values.
// ----------------------------------------------------------------------------
module pixel_saturation_contrast_invert_unit #(
  parameter int SCALE_FRAC_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [15:0] wr_data,
  // input beat
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  input  logic [7:0]  alpha_in,
  // result beat
  output logic        done,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out,
  output logic [7:0]  alpha_out,
  output logic        input_was_dark
);
  import psci_pkg::*;

  // configuration registers
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode  <= MODE_SAT;
      cfg.sat   <= SAT_RST;
      cfg.dark  <= DARK_RST;
      cfg.light <= LIGHT_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_MODE:  cfg.mode  <= wr_data[0];
        REG_SAT:   cfg.sat   <= wr_data;
        REG_DARK:  cfg.dark  <= wr_data;
        REG_LIGHT: cfg.light <= wr_data;
        default: ;
      endcase
    end
  end

  // pipe accepts every cycle
  assign busy = 1'b0;

  logic                  accept;
  logic                  f_valid;
  front_t                f_out;
  logic                  m_valid;
  logic [2:0][NUM_W-1:0] m_num;
  logic [CH_W-1:0]       m_delta;
  side_t                 m_side;
  logic                  q_valid;
  rgb_t                  q_quo;
  side_t                 q_side;

  assign accept = start & ~busy;

  psci_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .pix_in    ({blue_in, green_in, red_in}),
    .alpha_in  (alpha_in),
    .cfg       (cfg),
    .out_valid (f_valid),
    .out       (f_out)
  );

  psci_mul #(
    .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
  ) u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in        (f_out),
    .out_valid (m_valid),
    .num       (m_num),
    .delta     (m_delta),
    .side      (m_side)
  );

  psci_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (m_valid),
    .num       (m_num),
    .delta     (m_delta),
    .side_in   (m_side),
    .out_valid (q_valid),
    .quo_out   (q_quo),
    .side_out  (q_side)
  );

  // final stage: apply drop, then contrast remap
  rgb_t           res;
  rgb_t           fin;
  logic [CH_W:0]  up;
  logic [CH_W-1:0] drop;

  always_comb begin
    up   = '0;
    drop = '0;
    for (int i = 0; i < 3; i++) begin
      drop = q_side.capped ? q_quo[i] : q_side.drop_nc[i];
      res[i] = q_side.gray ? q_side.tag.ch[i] : (q_side.hi - drop);
      if (q_side.tag.mode == MODE_CONTRAST) begin
        if (q_side.tag.dark) begin
          up     = (CH_W+1)'(res[i]) + (CH_W+1)'(CH_MAX);
          fin[i] = up[CH_W:1];
        end else begin
          fin[i] = res[i] >> 1;
        end
      end else begin
        fin[i] = res[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= q_valid;
    end
    red_out        <= fin[0];
    green_out      <= fin[1];
    blue_out       <= fin[2];
    alpha_out      <= (q_side.tag.mode == MODE_CONTRAST) ? CH_MAX : q_side.tag.alpha;
    input_was_dark <= q_side.tag.dark;
  end

endmodule

FILE: sim/saturation_contrast_checker.sv
// ----------------------------------------------------------------------------
// saturation_contrast_checker
// Watches the register write port and both beat channels of the pixel
// saturation / contrast invert unit. It keeps its own register copy, predicts
// each result pixel at the input beat, queues it and compares every result
// beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module saturation_contrast_checker #(
  parameter int FRAC_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [15:0] wr_data,
  input  logic        start,
  input  logic        busy,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  input  logic [7:0]  alpha_in,
  input  logic        done,
  input  logic [7:0]  red_out,
  input  logic [7:0]  green_out,
  input  logic [7:0]  blue_out,
  input  logic [7:0]  alpha_out,
  input  logic        input_was_dark,
  output int          mismatch_count,
  output int          pixels_in_flight
);
  import psci_pkg::*;

  // Rec.709 weights in Q0.16 and the half-scale luma threshold
  localparam int unsigned WEIGHT_R   = 13933;
  localparam int unsigned WEIGHT_G   = 46871;
  localparam int unsigned WEIGHT_B   = 4732;
  localparam int unsigned HALF_LUMA  = 255 * 32768;

  // index 0 red, 1 green, 2 blue
  typedef logic [2:0][7:0] color_t;

  typedef struct packed {
    color_t     color;
    logic [7:0] alpha;
    logic       dark;
  } pixel_result_t;

  // register copy
  logic        cfg_mode;
  logic [15:0] sat_scale;
  logic [15:0] dark_scale;
  logic [15:0] light_scale;

  pixel_result_t expected_pixels[$];
  pixel_result_t want;
  int            results_seen;

  initial begin
    mismatch_count   = 0;
    pixels_in_flight = 0;
    results_seen     = 0;
  end

  // Pull every channel toward the max channel by min(scale, hi/delta),
  // truncating the exact value; gray pixels pass as they are.
  function automatic color_t scale_saturation(color_t c, logic [15:0] scale);
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [31:0] span;
    logic [31:0] d;
    logic [31:0] drop;
    logic        capped;
    color_t      res;
    int          i;
    hi = c[0];
    lo = c[0];
    for (i = 1; i < 3; i++) begin
      if (c[i] > hi) hi = c[i];
      if (c[i] < lo) lo = c[i];
    end
    span = 32'(hi - lo);
    if (span == 0) return c;
    capped = (32'(scale) * span) >= (32'(hi) << FRAC_BITS);
    for (i = 0; i < 3; i++) begin
      d = 32'(hi - c[i]);
      if (capped)
        drop = (d * 32'(hi) + span - 1) / span;
      else
        drop = (d * 32'(scale) + ((32'd1 << FRAC_BITS) - 1)) >> FRAC_BITS;
      if (drop > 32'(hi)) drop = 32'(hi);
      res[i] = hi - drop[7:0];
    end
    return res;
  endfunction

  function automatic pixel_result_t predict_pixel(logic [7:0] r, logic [7:0] g,
                                                  logic [7:0] b, logic [7:0] a);
    color_t        c;
    int unsigned   luma;
    logic          is_dark;
    logic [8:0]    lifted;
    pixel_result_t res;
    int            i;
    c       = {b, g, r};
    luma    = WEIGHT_R * r + WEIGHT_G * g + WEIGHT_B * b;
    is_dark = luma < HALF_LUMA;
    res.alpha = a;
    if (cfg_mode == MODE_SAT) begin
      c = scale_saturation(c, sat_scale);
    end else begin
      // invert, desaturate by brightness class, then fold into a half range
      for (i = 0; i < 3; i++) c[i] = 8'd255 - c[i];
      c = scale_saturation(c, is_dark ? dark_scale : light_scale);
      for (i = 0; i < 3; i++) begin
        lifted = is_dark ? 9'(c[i]) + 9'd255 : 9'(c[i]);
        c[i]   = lifted[8:1];
      end
      res.alpha = 8'd255;
    end
    res.color = c;
    res.dark  = is_dark;
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, int got_value, int want_value);
    if (got_value != want_value)
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                results_seen, name, got_value, want_value));
  endtask

  // result beats are compared before the same edge's input beat is queued
  always @(posedge clk) begin
    if (rst) begin
      cfg_mode    <= MODE_SAT;
      sat_scale   <= SAT_RST;
      dark_scale  <= DARK_RST;
      light_scale <= LIGHT_RST;
      expected_pixels.delete();
    end else begin
      if (done) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("result beat with no pixel in flight");
        end else begin
          want = expected_pixels.pop_front();
          check_field("red_out",        red_out,        want.color[0]);
          check_field("green_out",      green_out,      want.color[1]);
          check_field("blue_out",       blue_out,       want.color[2]);
          check_field("alpha_out",      alpha_out,      want.alpha);
          check_field("input_was_dark", input_was_dark, want.dark);
          results_seen++;
        end
      end
      if (start && !busy)
        expected_pixels.push_back(predict_pixel(red_in, green_in, blue_in, alpha_in));
      if (wr_en) begin
        case (wr_index)
          REG_MODE:  cfg_mode    <= wr_data[0];
          REG_SAT:   sat_scale   <= wr_data;
          REG_DARK:  dark_scale  <= wr_data;
          REG_LIGHT: light_scale <= wr_data;
          default: ;
        endcase
      end
    end
    pixels_in_flight = expected_pixels.size();
  end

endmodule

FILE: sim/tb_pixel_saturation_contrast_invert_unit.sv
// ----------------------------------------------------------------------------
// tb_pixel_saturation_contrast_invert_unit
// Drives pixel beats in random bursts through the unit under a series of
// register settings (both modes, zero and full scale), starting with a short
// directed set of corner pixels. Checking is done by the checker instance.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_pixel_saturation_contrast_invert_unit;
  import psci_pkg::*;

  localparam int FRAC_BITS     = 12;
  localparam int DRAIN_CYCLES  = 16;    // pipe depth plus margin
  localparam int IDLE_LIMIT    = 500;   // cycles with no beat before giving up
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_PIXELS  = 116;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } rgba_t;

  logic        clk;
  logic        rst;
  logic        wr_en;
  logic [1:0]  wr_index;
  logic [15:0] wr_data;
  logic        start;
  logic        busy;
  logic [7:0]  red_in;
  logic [7:0]  green_in;
  logic [7:0]  blue_in;
  logic [7:0]  alpha_in;
  logic        done;
  logic [7:0]  red_out;
  logic [7:0]  green_out;
  logic [7:0]  blue_out;
  logic [7:0]  alpha_out;
  logic        input_was_dark;
  int          mismatch_count;
  int          pixels_in_flight;
  int          burst_left;
  int          idle_cycles;

  // black, white, grays on both sides of the luma threshold, primaries,
  // nearly gray pixels and plain mixed colors
  rgba_t directed_pixels [12] = '{
    '{8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd255, 8'd255, 8'd255, 8'd255},
    '{8'd128, 8'd128, 8'd128, 8'd170},
    '{8'd127, 8'd127, 8'd127, 8'd85},
    '{8'd255, 8'd0,   8'd0,   8'd255},
    '{8'd0,   8'd255, 8'd0,   8'd0},
    '{8'd0,   8'd0,   8'd255, 8'd128},
    '{8'd1,   8'd0,   8'd0,   8'd1},
    '{8'd255, 8'd254, 8'd253, 8'd254},
    '{8'd200, 8'd100, 8'd50,  8'd77},
    '{8'd12,  8'd200, 8'd255, 8'd3},
    '{8'd128, 8'd127, 8'd128, 8'd200}
  };

  pixel_saturation_contrast_invert_unit #(
    .SCALE_FRAC_BITS(FRAC_BITS)
  ) u_top (
    .clk(clk), .rst(rst),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .start(start), .busy(busy),
    .red_in(red_in), .green_in(green_in), .blue_in(blue_in), .alpha_in(alpha_in),
    .done(done),
    .red_out(red_out), .green_out(green_out), .blue_out(blue_out),
    .alpha_out(alpha_out), .input_was_dark(input_was_dark)
  );

  saturation_contrast_checker #(
    .FRAC_BITS(FRAC_BITS)
  ) u_checker (
    .clk(clk), .rst(rst),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .start(start), .busy(busy),
    .red_in(red_in), .green_in(green_in), .blue_in(blue_in), .alpha_in(alpha_in),
    .done(done),
    .red_out(red_out), .green_out(green_out), .blue_out(blue_out),
    .alpha_out(alpha_out), .input_was_dark(input_was_dark),
    .mismatch_count(mismatch_count), .pixels_in_flight(pixels_in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [7:0] extreme_level();
    case ($urandom_range(0, 2))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // uniform colors in two of five cases, plus near-gray, saturated and near-threshold ones
  function automatic rgba_t random_pixel();
    rgba_t      p;
    logic [7:0] base;
    p.a = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 4))
      2: begin
        base = 8'($urandom_range(0, 255));
        p.r  = base ^ 8'($urandom_range(0, 3));
        p.g  = base ^ 8'($urandom_range(0, 3));
        p.b  = base ^ 8'($urandom_range(0, 3));
      end
      3: begin
        p.r = extreme_level();
        p.g = extreme_level();
        p.b = extreme_level();
      end
      4: begin
        base = 8'($urandom_range(120, 135));
        p.r  = base ^ 8'($urandom_range(0, 7));
        p.g  = base ^ 8'($urandom_range(0, 7));
        p.b  = base ^ 8'($urandom_range(0, 7));
      end
      default: begin
        p.r = 8'($urandom_range(0, 255));
        p.g = 8'($urandom_range(0, 255));
        p.b = 8'($urandom_range(0, 255));
      end
    endcase
    return p;
  endfunction

  function automatic logic [15:0] pick_scale();
    case ($urandom_range(0, 4))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return SAT_RST;
      3:       return 16'($urandom_range(0, 8191));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // bursts of random length; some long bursts with no gap at all
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(20, 60);
        gap        = 0;
      end else begin
        burst_left = $urandom_range(1, 12);
        gap        = $urandom_range(1, 6);
      end
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  // one pixel beat; returns at the falling edge after acceptance
  task automatic send_pixel(rgba_t p);
    pace();
    start    <= 1'b1;
    red_in   <= p.r;
    green_in <= p.g;
    blue_in  <= p.b;
    alpha_in <= p.a;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pixels_in_flight != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(negedge clk);
  endtask

  // registers change only with the pipe empty
  task automatic load_config(logic mode, logic [15:0] sat, logic [15:0] dark,
                             logic [15:0] light);
    drain();
    write_reg(REG_MODE, {15'($urandom_range(0, 32767)), mode});
    write_reg(REG_SAT, sat);
    write_reg(REG_DARK, dark);
    write_reg(REG_LIGHT, light);
    wr_en <= 1'b0;
  endtask

  // watchdog: too long with neither an input nor a result beat
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || done)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    int          phase;
    logic        cfg_mode;
    logic [15:0] cfg_sat;
    logic [15:0] cfg_dark;
    logic [15:0] cfg_light;
    rst        = 1'b1;
    wr_en      = 1'b0;
    wr_index   = REG_MODE;
    wr_data    = 16'd0;
    start      = 1'b0;
    red_in     = 8'd0;
    green_in   = 8'd0;
    blue_in    = 8'd0;
    alpha_in   = 8'd0;
    burst_left = 0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // corner pixels under the reset settings, then in contrast mode
    foreach (directed_pixels[i]) send_pixel(directed_pixels[i]);
    load_config(MODE_CONTRAST, SAT_RST, DARK_RST, LIGHT_RST);
    foreach (directed_pixels[i]) send_pixel(directed_pixels[i]);

    // first phases pin the scale extremes, the rest are random settings
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin
          cfg_mode = MODE_SAT;      cfg_sat  = 16'd0;
          cfg_dark = 16'hFFFF;      cfg_light = 16'd0;
        end
        1: begin
          cfg_mode = MODE_SAT;      cfg_sat  = 16'hFFFF;
          cfg_dark = 16'd0;         cfg_light = 16'hFFFF;
        end
        2: begin
          cfg_mode = MODE_CONTRAST; cfg_sat  = 16'hFFFF;
          cfg_dark = 16'd0;         cfg_light = 16'hFFFF;
        end
        3: begin
          cfg_mode = MODE_CONTRAST; cfg_sat  = 16'd0;
          cfg_dark = 16'hFFFF;      cfg_light = 16'd0;
        end
        default: begin
          cfg_mode  = $urandom_range(0, 1) ? MODE_CONTRAST : MODE_SAT;
          cfg_sat   = pick_scale();
          cfg_dark  = pick_scale();
          cfg_light = pick_scale();
        end
      endcase
      load_config(cfg_mode, cfg_sat, cfg_dark, cfg_light);
      repeat (PHASE_PIXELS) send_pixel(random_pixel());
    end

    drain();
    if (mismatch_count == 0 && pixels_in_flight == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
